// ===== rtl/rc5_block_cipher_fixed_key_defines.svh =====
// ----------------------------------------------------------------------------
// rc5 block cipher assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef RC5_BLOCK_CIPHER_FIXED_KEY_DEFINES_SVH
`define RC5_BLOCK_CIPHER_FIXED_KEY_DEFINES_SVH

// same-cycle implication, off while reset is high
`define RC5_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define RC5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// behavior coming out of reset
`define RC5_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== rtl/rc5_pkg.sv =====
// ----------------------------------------------------------------------------
// rc5 package
// round-key table, item type and rotate helpers for the rc5-32/12 pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rc5_pkg;

  localparam int ROUNDS      = 12;
  localparam int HALF_ROUNDS = 2 * ROUNDS;
  localparam int KEY_WORDS   = 2 * ROUNDS + 2;
  localparam logic MODE_ENC  = 1'b0;
  localparam logic MODE_DEC  = 1'b1;

  localparam logic [31:0] ROUND_KEYS [KEY_WORDS] = '{
    32'h00000000, 32'h00000000,
    32'h46F8E8C5, 32'h460C6085, 32'h70F83B8A, 32'h284B8303,
    32'h513E1454, 32'hF621ED22, 32'h3125065D, 32'h11A83A5D,
    32'hD427686B, 32'h713AD82D, 32'h4B792F99, 32'h2799A4DD,
    32'hA7901C49, 32'hDEDE871A, 32'h36C03196, 32'hA7EFC249,
    32'h61A78BB8, 32'h3B0A1D2B, 32'h4DBFCA76, 32'hAE162167,
    32'h30D76B0A, 32'h43192304, 32'hF6CC1431, 32'h65046380
  };

  typedef struct packed {
    logic        mode;
    logic [31:0] a;
    logic [31:0] b;
  } rc5_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] t;
    t = {x, x} << r;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] r);
    logic [63:0] t;
    t = {x, x} >> r;
    return t[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rc5_cell.sv =====
// ----------------------------------------------------------------------------
// rc5 half-round cell
// one pipeline slot: updates one word per cycle unless stalled, encrypt or decrypt per item
// ----------------------------------------------------------------------------
`default_nettype none

module rc5_cell import rc5_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        odd_half,
  input  wire logic [31:0] enc_key,
  input  wire logic [31:0] dec_key,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire rc5_item_t   up_item,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output rc5_item_t        dn_item
);

  logic      vld;
  rc5_item_t item;
  rc5_item_t item_next;

  assign up_ready = !vld || dn_ready;
  assign dn_valid = vld;
  assign dn_item  = item;

  // encrypt: even half updates a, odd half b
  // decrypt: even half undoes b, odd half undoes a
  always_comb begin
    item_next = up_item;
    if (up_item.mode == MODE_ENC) begin
      if (!odd_half) begin
        item_next.a = rotl(up_item.a ^ up_item.b, up_item.b[4:0]) + enc_key;
      end else begin
        item_next.b = rotl(up_item.b ^ up_item.a, up_item.a[4:0]) + enc_key;
      end
    end else begin
      if (!odd_half) begin
        item_next.b = rotr(up_item.b - dec_key, up_item.a[4:0]) ^ up_item.a;
      end else begin
        item_next.a = rotr(up_item.a - dec_key, up_item.b[4:0]) ^ up_item.b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rc5_block_cipher_fixed_key.sv =====
// ----------------------------------------------------------------------------
// rc5-32/12 block cipher, fixed round keys
// pipelined encrypt/decrypt of 64-bit blocks, mode chosen per block
// ----------------------------------------------------------------------------
// A chain of 24 half-round cells, one word update each, carries every block
// together with its mode bit, so encrypt and decrypt blocks mix freely. One
// block is taken per clock while in_ready is high; a block passes through every
// cell register in turn. Each cell holds its item until the next cell frees, so
// a stall at the output fills the empty slots before in_ready drops.
`default_nettype none

module rc5_block_cipher_fixed_key import rc5_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [63:0] data_block,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_block
);

  logic      valid_c [HALF_ROUNDS+1];
  logic      ready_c [HALF_ROUNDS+1];
  rc5_item_t item_c  [HALF_ROUNDS+1];

  assign valid_c[0]       = in_valid;
  assign in_ready         = ready_c[0];
  assign item_c[0].mode   = mode;
  assign item_c[0].a      = data_block[63:32];
  assign item_c[0].b      = data_block[31:0];

  for (genvar h = 0; h < HALF_ROUNDS; h++) begin : g_cell
    // encrypt runs keys upward from the third word, decrypt downward from the last
    rc5_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .odd_half (1'((h % 2) == 1)),
      .enc_key  (ROUND_KEYS[2 + h]),
      .dec_key  (ROUND_KEYS[KEY_WORDS - 1 - h]),
      .up_valid (valid_c[h]),
      .up_ready (ready_c[h]),
      .up_item  (item_c[h]),
      .dn_valid (valid_c[h+1]),
      .dn_ready (ready_c[h+1]),
      .dn_item  (item_c[h+1])
    );
  end

  assign out_valid              = valid_c[HALF_ROUNDS];
  assign ready_c[HALF_ROUNDS]   = out_ready;
  assign result_block           = {item_c[HALF_ROUNDS].a, item_c[HALF_ROUNDS].b};

endmodule

`default_nettype wire

// ===== rtl/rc5_chk.sv =====
// ----------------------------------------------------------------------------
// rc5 port checker
// port-level properties of the cipher pipeline, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc5_block_cipher_fixed_key_defines.svh"

module rc5_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_block
);

  // an empty or draining output slot frees the whole chain
  `RC5_ASSERT_NOW(a_ready_when_free, (!out_valid || out_ready), in_ready, "in_ready low")
  `RC5_ASSERT_RST(a_empty_after_rst, !out_valid, "result shown right after reset")
  `RC5_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), out_valid, "result dropped")
  `RC5_ASSERT_NEXT(a_out_stable, (out_valid && !out_ready), $stable(result_block), "result moved")

endmodule

bind rc5_block_cipher_fixed_key rc5_chk u_rc5_chk (.*);

`default_nettype wire
